// ----- design/ssnf_pkg.sv -----
// ----------------------------------------------------------------------------
// ssnf_pkg
// Shared types, constants and segment tables for the seven-segment number
// formatter pipeline.
// ----------------------------------------------------------------------------
package ssnf_pkg;

  localparam int NUM_DIGITS   = 4;
  localparam int POS_W        = $clog2(NUM_DIGITS);
  localparam int CNT_W        = $clog2(NUM_DIGITS + 1);
  localparam int CMD_W        = 3;
  localparam int VALUE_W      = 25;
  localparam int MAG_W        = VALUE_W - 1;
  localparam int BCD_DIGITS   = 7;
  localparam int BCD_W        = 4 * BCD_DIGITS;
  localparam int IDX_W        = $clog2(BCD_DIGITS);
  localparam int DABBLE_STAGES = 3;
  localparam int DABBLE_STEPS = MAG_W / DABBLE_STAGES;
  localparam int SEG_W        = 8;
  localparam int S_TDATA_W    = ((VALUE_W + 7) / 8) * 8;
  localparam int M_TDATA_W    = ((POS_W + SEG_W + 7) / 8) * 8;

  // Largest magnitude that any mode can show (9999.999 in thousandths)
  localparam logic signed [VALUE_W-1:0] VALUE_MAX = 25'sd9999999;

  typedef enum logic [CMD_W-1:0] {
    CMD_INT  = 3'd0,
    CMD_DEC  = 3'd1,
    CMD_OUFL = 3'd2,
    CMD_INF  = 3'd3,
    CMD_IDLE = 3'd4
  } cmd_t;

  typedef logic [SEG_W-1:0] seg_t;
  typedef logic [POS_W-1:0] pos_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam seg_t SEG_MINUS = 8'h40;
  localparam seg_t SEG_DP    = 8'h80;

  // Text patterns, leftmost digit in the lowest slot
  localparam seg_t [NUM_DIGITS-1:0] TXT_OUFL = {8'h38, 8'h71, 8'h3E, 8'h3F};
  localparam seg_t [NUM_DIGITS-1:0] TXT_INF  = {8'h00, 8'h71, 8'h37, 8'h30};
  localparam seg_t [NUM_DIGITS-1:0] TXT_IDLE = {8'h5B, 8'h3F, 8'h07, 8'h06};
  localparam cnt_t CNT_OUFL = 3'd4;
  localparam cnt_t CNT_INF  = 3'd3;
  localparam cnt_t CNT_IDLE = 3'd4;

  // Conversion work item: BCD digits grow while binary bits shift out
  typedef struct packed {
    cmd_t             cmd;
    logic             neg;
    logic             big;
    logic [BCD_W-1:0] bcd;
    logic [MAG_W-1:0] bin;
  } work_t;

  // Formatted request: one pattern per position, first lit position, count
  typedef struct packed {
    seg_t [NUM_DIGITS-1:0] segs;
    pos_t                  first;
    cnt_t                  count;
  } frame_t;

  function automatic seg_t glyph(input logic [3:0] d);
    seg_t g;
    unique case (d)
      4'd0:    g = 8'h3F;
      4'd1:    g = 8'h06;
      4'd2:    g = 8'h5B;
      4'd3:    g = 8'h4F;
      4'd4:    g = 8'h66;
      4'd5:    g = 8'h6D;
      4'd6:    g = 8'h7D;
      4'd7:    g = 8'h07;
      4'd8:    g = 8'h7F;
      4'd9:    g = 8'h6F;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

endpackage

// ----- design/ssnf_dabble.sv -----
// ----------------------------------------------------------------------------
// ssnf_dabble
// One pipeline stage of the binary to BCD conversion: a fixed number of
// shift-and-add-3 steps, with valid/ready flow control.
// ----------------------------------------------------------------------------
module ssnf_dabble (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  ssnf_pkg::work_t in_work,
  output logic            out_valid,
  input  logic            out_ready,
  output ssnf_pkg::work_t out_work
);
  import ssnf_pkg::*;

  work_t step;

  always_comb begin
    logic [BCD_W-1:0] b;
    logic [MAG_W-1:0] r;
    step = in_work;
    b    = in_work.bcd;
    r    = in_work.bin;
    for (int s = 0; s < DABBLE_STEPS; s++) begin
      for (int i = 0; i < BCD_DIGITS; i++) begin
        if (b[4*i +: 4] >= 4'd5) begin
          b[4*i +: 4] = b[4*i +: 4] + 4'd3;
        end
      end
      {b, r} = {b[BCD_W-2:0], r, 1'b0};
    end
    step.bcd = b;
    step.bin = r;
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      out_work <= step;
    end
  end

endmodule

// ----- design/ssnf_format.sv -----
// ----------------------------------------------------------------------------
// ssnf_format
// Turns converted digits and the command into per-position segment patterns,
// the first lit position and the number of lit digits. Requests that light
// nothing are dropped here.
// ----------------------------------------------------------------------------
module ssnf_format (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssnf_pkg::work_t  in_work,
  output logic             out_valid,
  input  logic             out_ready,
  output ssnf_pkg::frame_t out_frame
);
  import ssnf_pkg::*;

  frame_t frame_next;

  always_comb begin
    logic [3:0]       d [BCD_DIGITS];
    cnt_t             int_n;
    cnt_t             dec_n;
    cnt_t             int_k;
    cnt_t             dec_l;
    logic             int_ok;
    logic             dec_ok;
    logic [IDX_W-1:0] idx;
    logic [3:0]       dig;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      d[i] = in_work.bcd[4*i +: 4];
    end
    int_n = (d[3] != 4'd0) ? 3'd4 : (d[2] != 4'd0) ? 3'd3 : (d[1] != 4'd0) ? 3'd2 : 3'd1;
    dec_n = (d[6] != 4'd0) ? 3'd4 : (d[5] != 4'd0) ? 3'd3 : (d[4] != 4'd0) ? 3'd2 : 3'd1;
    int_ok = !in_work.big && (d[6] == 4'd0) && (d[5] == 4'd0) && (d[4] == 4'd0)
             && (!in_work.neg || (d[3] == 4'd0));
    dec_ok = !in_work.big && !(in_work.neg && (d[6] != 4'd0));
    // Minus takes one extra position ahead of the digits
    int_k = int_n + {{(CNT_W-1){1'b0}}, in_work.neg};
    dec_l = dec_n + {{(CNT_W-1){1'b0}}, in_work.neg};
    idx   = '0;
    dig   = '0;
    frame_next = '0;
    unique case (in_work.cmd)
      CMD_INT: begin
        if (int_ok) begin
          frame_next.count = int_k;
          frame_next.first = pos_t'(cnt_t'(NUM_DIGITS) - int_k);
          for (int p = 0; p < NUM_DIGITS; p++) begin
            idx = IDX_W'(NUM_DIGITS - 1 - p);
            dig = in_work.bcd[4*idx +: 4];
            if (in_work.neg && (pos_t'(p) == frame_next.first)) begin
              frame_next.segs[p] = SEG_MINUS;
            end else begin
              frame_next.segs[p] = glyph(dig);
            end
          end
        end
      end
      CMD_DEC: begin
        if (dec_ok) begin
          frame_next.count = cnt_t'(NUM_DIGITS);
          frame_next.first = '0;
          // Position p shows digit (2 + L - p), where L ends the integer part
          for (int p = 0; p < NUM_DIGITS; p++) begin
            idx = IDX_W'(dec_l + 3'd2 - cnt_t'(p));
            dig = (idx < IDX_W'(BCD_DIGITS)) ? in_work.bcd[4*idx +: 4] : 4'd0;
            if (in_work.neg && (p == 0)) begin
              frame_next.segs[p] = SEG_MINUS;
            end else begin
              frame_next.segs[p] = glyph(dig)
                                 | ((cnt_t'(p) == dec_l - 3'd1) ? SEG_DP : 8'h00);
            end
          end
        end
      end
      CMD_OUFL: begin
        frame_next.segs  = TXT_OUFL;
        frame_next.count = CNT_OUFL;
      end
      CMD_INF: begin
        frame_next.segs  = TXT_INF;
        frame_next.count = CNT_INF;
      end
      CMD_IDLE: begin
        frame_next.segs  = TXT_IDLE;
        frame_next.count = CNT_IDLE;
      end
      default: frame_next = '0;
    endcase
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid && (frame_next.count != '0);
    end
    if (in_valid && in_ready) begin
      out_frame <= frame_next;
    end
  end

endmodule

// ----- design/ssnf_serial.sv -----
// ----------------------------------------------------------------------------
// ssnf_serial
// Output register: walks the lit positions of one formatted request, one
// digit per transaction, and loads the next request as the last one leaves.
// ----------------------------------------------------------------------------
module ssnf_serial (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  ssnf_pkg::frame_t in_frame,
  output logic             out_valid,
  input  logic             out_ready,
  output ssnf_pkg::pos_t   out_pos,
  output ssnf_pkg::seg_t   out_seg,
  output logic             out_last
);
  import ssnf_pkg::*;

  logic   valid;
  frame_t frame;
  pos_t   j;

  assign out_pos   = frame.first + j;
  assign out_seg   = frame.segs[out_pos];
  assign out_last  = (cnt_t'(j) == frame.count - cnt_t'(1));
  assign out_valid = valid;
  assign in_ready  = !valid || (out_ready && out_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      j     <= '0;
    end else if (in_ready) begin
      valid <= in_valid;
      j     <= '0;
    end else if (out_ready) begin
      // advance to the next lit position
      j <= j + pos_t'(1);
    end
    if (in_valid && in_ready) begin
      frame <= in_frame;
    end
  end

endmodule

// ----- design/seven_segment_number_formatter_core.sv -----
// ----------------------------------------------------------------------------
// seven_segment_number_formatter_core
// Formats one display request into per-digit segment patterns for a
// four-digit seven-segment display.
//
// A request (tuser = cmd, tdata = value) enters a six-stage pipeline: input
// register with sign/range check, three binary to BCD stages of eight steps
// each, a format stage and an output register. A request may be taken on
// every cycle. Each lit digit then leaves as one transaction, left to right,
// with tlast on the final one. A request occupies the output for one
// transaction per lit digit: one to four for integers, four for decimals
// and for the overflow and idle texts, three for the INF text. Values out
// of range and unused commands light nothing and are dropped inside. The
// sustained request rate is therefore set by the single output port.
// ----------------------------------------------------------------------------
module seven_segment_number_formatter_core (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [ssnf_pkg::S_TDATA_W-1:0]   s_tdata,  // [24:0] value
  input  logic [ssnf_pkg::CMD_W-1:0]       s_tuser,  // [2:0] cmd
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [ssnf_pkg::M_TDATA_W-1:0]   m_tdata,  // [1:0] digit_pos, [9:2] segments
  output logic                             m_tlast
);
  import ssnf_pkg::*;

  logic signed [VALUE_W-1:0] value;
  logic        [MAG_W-1:0]   mag;

  logic   in_valid;
  logic   in_ready;
  work_t  in_work;

  logic   dab_valid [DABBLE_STAGES];
  logic   dab_ready [DABBLE_STAGES];
  work_t  dab_work  [DABBLE_STAGES];

  logic   fmt_valid;
  logic   fmt_ready;
  frame_t fmt_frame;

  pos_t   out_pos;
  seg_t   out_seg;

  assign value = signed'(s_tdata[VALUE_W-1:0]);
  assign mag   = value[VALUE_W-1] ? MAG_W'(-value) : MAG_W'(value);

  assign s_tready = !in_valid || in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
    if (s_tvalid && s_tready) begin
      in_work.cmd <= cmd_t'(s_tuser);
      in_work.neg <= value[VALUE_W-1];
      in_work.big <= (value > VALUE_MAX) || (value < -VALUE_MAX);
      in_work.bcd <= '0;
      in_work.bin <= mag;
    end
  end

  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
    logic  stg_in_valid;
    logic  stg_in_ready;
    work_t stg_in_work;
    if (g == 0) begin : g_first
      assign stg_in_valid = in_valid;
      assign stg_in_work  = in_work;
      assign in_ready     = stg_in_ready;
    end else begin : g_rest
      assign stg_in_valid     = dab_valid[g-1];
      assign stg_in_work      = dab_work[g-1];
      assign dab_ready[g-1]   = stg_in_ready;
    end
    ssnf_dabble u_dabble (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stg_in_valid),
      .in_ready  (stg_in_ready),
      .in_work   (stg_in_work),
      .out_valid (dab_valid[g]),
      .out_ready (dab_ready[g]),
      .out_work  (dab_work[g])
    );
  end

  ssnf_format u_format (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dab_valid[DABBLE_STAGES-1]),
    .in_ready  (dab_ready[DABBLE_STAGES-1]),
    .in_work   (dab_work[DABBLE_STAGES-1]),
    .out_valid (fmt_valid),
    .out_ready (fmt_ready),
    .out_frame (fmt_frame)
  );

  ssnf_serial u_serial (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (fmt_valid),
    .in_ready  (fmt_ready),
    .in_frame  (fmt_frame),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_pos   (out_pos),
    .out_seg   (out_seg),
    .out_last  (m_tlast)
  );

  assign m_tdata = {{(M_TDATA_W - SEG_W - POS_W){1'b0}}, out_seg, out_pos};

endmodule

// ----- verif/ssnf_scoreboard.sv -----
// ----------------------------------------------------------------------------
// ssnf_scoreboard
// Watches both stream channels of the seven-segment number formatter. Every
// accepted request is expanded into the digit transactions it should light,
// and every digit transaction leaving the block is compared field by field
// with the oldest one still owed.
// ----------------------------------------------------------------------------
module ssnf_scoreboard (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  input  logic                           s_tready,
  input  logic [ssnf_pkg::S_TDATA_W-1:0] s_tdata,   // [24:0] value
  input  logic [ssnf_pkg::CMD_W-1:0]     s_tuser,   // [2:0] cmd
  input  logic                           m_tvalid,
  input  logic                           m_tready,
  input  logic [ssnf_pkg::M_TDATA_W-1:0] m_tdata,   // [1:0] digit_pos, [9:2] segments
  input  logic                           m_tlast,
  output int                             errors,
  output int                             pending
);
  import ssnf_pkg::*;

  typedef struct packed {
    logic [POS_W-1:0] pos;
    logic [SEG_W-1:0] seg;
    logic             last;
  } digit_t;

  localparam logic [SEG_W-1:0] DIGIT_SHAPE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };
  localparam logic [SEG_W-1:0] OUFL_TEXT [4] = '{8'h3F, 8'h3E, 8'h71, 8'h38};
  localparam logic [SEG_W-1:0] INF_TEXT  [3] = '{8'h30, 8'h37, 8'h71};
  localparam logic [SEG_W-1:0] IDLE_TEXT [4] = '{8'h06, 8'h07, 8'h3F, 8'h5B};
  localparam int unsigned FRAC_DIV [3] = '{100, 10, 1};

  digit_t expected_digits[$];
  int     lit_now;

  function automatic int unsigned digit_count(input int unsigned m);
    int unsigned n;
    n = 1;
    while (m >= 10 && n < 9) begin
      m = m / 10;
      n++;
    end
    return n;
  endfunction

  // Digit i of an n-digit number, counted from the most significant end
  function automatic int unsigned nth_digit(input int unsigned m, input int unsigned n,
                                            input int unsigned i);
    int unsigned scale;
    scale = 1;
    for (int unsigned e = 0; e < n - 1 - i; e++) scale = scale * 10;
    return (m / scale) % 10;
  endfunction

  task automatic owe_digit(input int unsigned pos, input logic [SEG_W-1:0] seg);
    digit_t d;
    d.pos  = pos[POS_W-1:0];
    d.seg  = seg;
    d.last = 1'b0;
    if (lit_now < NUM_DIGITS) begin
      expected_digits.push_back(d);
      lit_now++;
    end
  endtask

  task automatic predict_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] raw);
    logic               neg;
    logic [VALUE_W-1:0] mag25;
    int unsigned        mag, ip, fr, n, lead, p, i;
    logic [SEG_W-1:0]   seg;
    neg     = raw[VALUE_W-1];
    mag25   = neg ? -raw : raw;
    mag     = 32'(mag25);
    lit_now = 0;
    case (cmd)
      CMD_INT: begin
        n = digit_count(mag);
        if (neg ? (n <= NUM_DIGITS - 1) : (n <= NUM_DIGITS)) begin
          lead = NUM_DIGITS - n;
          if (neg) owe_digit(lead - 1, SEG_MINUS);
          for (i = 0; i < n; i++) owe_digit(lead + i, DIGIT_SHAPE[nth_digit(mag, n, i)]);
        end
      end
      CMD_DEC: begin
        ip   = mag / 1000;
        fr   = mag % 1000;
        n    = digit_count(ip);
        lead = neg ? 1 : 0;
        if (n <= NUM_DIGITS - lead) begin
          if (neg) owe_digit(0, SEG_MINUS);
          for (i = 0; i < n; i++) begin
            seg = DIGIT_SHAPE[nth_digit(ip, n, i)];
            if (i == n - 1) seg = seg | SEG_DP;
            owe_digit(lead + i, seg);
          end
          // fraction digits are truncated, never rounded
          p = lead + n;
          i = 0;
          while (p < NUM_DIGITS && i < 3) begin
            owe_digit(p, DIGIT_SHAPE[(fr / FRAC_DIV[i]) % 10]);
            p++;
            i++;
          end
        end
      end
      CMD_OUFL: for (i = 0; i < 4; i++) owe_digit(i, OUFL_TEXT[i]);
      CMD_INF:  for (i = 0; i < 3; i++) owe_digit(i, INF_TEXT[i]);
      CMD_IDLE: for (i = 0; i < 4; i++) owe_digit(i, IDLE_TEXT[i]);
      default: ;
    endcase
    if (lit_now > 0) begin
      expected_digits[expected_digits.size() - 1].last = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("[%0t] digit mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    errors++;
  endtask

  task automatic check_digit();
    digit_t want;
    if (expected_digits.size() == 0) begin
      report_mismatch("unexpected transaction", int'(m_tdata), 0);
    end else begin
      want = expected_digits.pop_front();
      if (m_tdata[POS_W-1:0] !== want.pos)
        report_mismatch("digit_pos", int'(m_tdata[POS_W-1:0]), int'(want.pos));
      if (m_tdata[POS_W+SEG_W-1:POS_W] !== want.seg)
        report_mismatch("segments", int'(m_tdata[POS_W+SEG_W-1:POS_W]), int'(want.seg));
      if (m_tlast !== want.last)
        report_mismatch("last", int'(m_tlast), int'(want.last));
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      expected_digits.delete();
    end else begin
      if (m_tvalid && m_tready) check_digit();
      if (s_tvalid && s_tready) predict_request(s_tuser, s_tdata[VALUE_W-1:0]);
    end
    pending = expected_digits.size();
  end

endmodule

// ----- verif/tb_seven_segment_number_formatter_core.sv -----
// ----------------------------------------------------------------------------
// tb_seven_segment_number_formatter_core
// Drives display requests into the formatter: a directed set of range edges,
// zero, small negative decimals, every text mode and the unused commands,
// then random requests over four idle/stall phases. The scoreboard beside
// the block does the prediction and comparison.
// ----------------------------------------------------------------------------
module tb_seven_segment_number_formatter_core;
  import ssnf_pkg::*;

  localparam int RANDOM_ITEMS = 456;
  localparam int STALL_LIMIT  = 1000;
  localparam int DRAIN_WAIT   = 24;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;    // [24:0] value
  logic [CMD_W-1:0]     s_tuser = '0;    // [2:0] cmd
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;         // [1:0] digit_pos, [9:2] segments
  logic                 m_tlast;

  int errors, pending;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int quiet_cycles   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  seven_segment_number_formatter_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  ssnf_scoreboard scoreboard (
    .clk          (clk),
    .rst          (rst),
    .s_tvalid     (s_tvalid),
    .s_tready     (s_tready),
    .s_tdata      (s_tdata),
    .s_tuser      (s_tuser),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tlast      (m_tlast),
    .errors       (errors),
    .pending      (pending)
  );

  always @(negedge clk) m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // End the run if neither channel moves a transaction for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {{(S_TDATA_W - VALUE_W){1'b0}}, value};
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  function automatic logic [CMD_W-1:0] pick_cmd();
    int r;
    r = $urandom_range(99);
    if (r < 40) return CMD_INT;
    if (r < 80) return CMD_DEC;
    if (r < 87) return CMD_OUFL;
    if (r < 91) return CMD_INF;
    if (r < 95) return CMD_IDLE;
    return CMD_W'($urandom_range(CMD_IDLE + 1, (1 << CMD_W) - 1));
  endfunction

  // Mostly in-range numbers of random length, some at a power-of-ten boundary,
  // some over the whole 25-bit field
  function automatic logic [VALUE_W-1:0] pick_value(input logic [CMD_W-1:0] cmd);
    int r, d, mag;
    r = $urandom_range(99);
    if (r < 15) return VALUE_W'($urandom());
    d   = (cmd == CMD_DEC) ? $urandom_range(1, 8) : $urandom_range(1, 5);
    mag = $urandom_range(0, 10**d - 1);
    if (r < 27) mag = 10**d - 1 + $urandom_range(0, 1);
    return ($urandom_range(2) == 0) ? VALUE_W'(-mag) : VALUE_W'(mag);
  endfunction

  initial begin
    logic [CMD_W-1:0] cmd;
    repeat (6) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed: range edges, zero, small negative decimals, text modes
    send_request(CMD_INT, VALUE_W'(0));
    send_request(CMD_INT, VALUE_W'(9999));
    send_request(CMD_INT, VALUE_W'(10000));
    send_request(CMD_INT, VALUE_W'(-999));
    send_request(CMD_INT, VALUE_W'(-1000));
    send_request(CMD_INT, VALUE_W'(-7));
    send_request(CMD_INT, 25'h1000000);
    send_request(CMD_INT, 25'h0FFFFFF);
    send_request(CMD_DEC, VALUE_W'(0));
    send_request(CMD_DEC, VALUE_W'(9999999));
    send_request(CMD_DEC, VALUE_W'(10000000));
    send_request(CMD_DEC, VALUE_W'(-1));
    send_request(CMD_DEC, VALUE_W'(-500));
    send_request(CMD_DEC, VALUE_W'(-999999));
    send_request(CMD_DEC, VALUE_W'(-1000000));
    send_request(CMD_DEC, VALUE_W'(12349));
    send_request(CMD_DEC, VALUE_W'(5));
    send_request(CMD_DEC, 25'h1000000);
    send_request(CMD_OUFL, 25'h1FFFFFF);
    send_request(CMD_INF, VALUE_W'(0));
    send_request(CMD_IDLE, 25'h1555555);
    for (int c = CMD_IDLE + 1; c < (1 << CMD_W); c++) send_request(CMD_W'(c), VALUE_W'(123));
    drain();

    // Random: no idling, sender idle, receiver stall, both
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      for (int k = 0; k < RANDOM_ITEMS / 4; k++) begin
        cmd = pick_cmd();
        send_request(cmd, pick_value(cmd));
      end
      // hold off until every owed digit is out
      drain();
    end

    recv_stall_pct = 0;
    repeat (DRAIN_WAIT) @(negedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
